@@ sv/dlr_pkg.sv @@
package dlr_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int POS_W      = COORD_BITS + FRAC_BITS;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int QUOT_W     = FRAC_BITS + 1;
	localparam int STEP_W     = FRAC_BITS + 2;
	localparam int CNT_W      = $clog2(FRAC_BITS);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic load;
		logic div_en;
		logic tick;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic at_end;
	} sts_t;

endpackage

@@ sv/dlr_div_lane.sv @@
module dlr_div_lane (
	input  logic                                    clk,
	input  logic                                    load,
	input  logic [dlr_pkg::COORD_BITS-1:0]          mag_d,
	input  logic                                    neg,
	input  logic [dlr_pkg::COORD_BITS-1:0]          len,
	input  logic                                    step_en,
	output logic signed [dlr_pkg::STEP_W-1:0]       step
);

	logic [dlr_pkg::COORD_BITS-1:0] rem_q;
	logic [dlr_pkg::QUOT_W-1:0]     quot_q;
	logic                           neg_q;

	logic [dlr_pkg::COORD_BITS:0]   rem2;
	logic [dlr_pkg::COORD_BITS:0]   rem_sub;
	logic                           ge;
	logic [dlr_pkg::STEP_W-1:0]     mag_step;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem2    = {rem_q, 1'b0};
		ge      = rem2 >= {1'b0, len};
		rem_sub = ge ? (rem2 - {1'b0, len}) : rem2;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= neg;
			if (mag_d == len) begin
				quot_q <= dlr_pkg::QUOT_W'(1);
				rem_q  <= '0;
			end else begin
				quot_q <= '0;
				rem_q  <= mag_d;
			end
		end else if (step_en) begin
			rem_q  <= rem_sub[dlr_pkg::COORD_BITS-1:0];
			quot_q <= {quot_q[dlr_pkg::QUOT_W-2:0], ge};
		end
	end

	assign mag_step = {1'b0, quot_q};
	assign step     = neg_q ? -$signed(mag_step) : $signed(mag_step);

endmodule

@@ sv/dlr_datapath.sv @@
module dlr_datapath (
	input  logic                                clk,
	input  dlr_pkg::cmd_t                       cmd,
	output dlr_pkg::sts_t                       sts,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] stop_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] stop_y,
	input  logic [31:0]                         line_color,
	output logic signed [dlr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [dlr_pkg::COORD_BITS-1:0] pixel_y,
	output logic [31:0]                         pixel_color,
	output logic                                last_pixel
);

	localparam int C = dlr_pkg::COORD_BITS;
	localparam int F = dlr_pkg::FRAC_BITS;
	localparam int P = dlr_pkg::POS_W;
	localparam int S = dlr_pkg::STEP_W;
	localparam int D = dlr_pkg::DIFF_W;

	function automatic logic near_end(input logic [P:0] d);
		logic [C:0] hi;
		hi = d[P:F];
		return (hi == '0) || ((&hi) && (d[F-1:0] != '0));
	endfunction

	function automatic logic [C-1:0] trunc_pos(input logic [P-1:0] p);
		return p[P-1:F] + C'(p[P-1] && (p[F-1:0] != '0));
	endfunction

	logic [P-1:0]  pos_x_q, pos_y_q;
	logic [C-1:0]  tgt_x_q, tgt_y_q;
	logic [C-1:0]  len_q;
	logic [31:0]   color_q;
	logic [C-1:0]  pix_x_q, pix_y_q;
	logic [31:0]   pix_color_q;
	logic          last_q;

	logic [D-1:0]  dx, dy, dx_abs, dy_abs;
	logic [C-1:0]  mag_x, mag_y, len_w, len_in;
	logic signed [S-1:0] step_x, step_y;
	logic [P-1:0]  nx, ny;
	logic [P:0]    diff_x, diff_y;

	assign dx     = {stop_x[C-1], stop_x} - {start_x[C-1], start_x};
	assign dy     = {stop_y[C-1], stop_y} - {start_y[C-1], start_y};
	assign dx_abs = dx[D-1] ? -dx : dx;
	assign dy_abs = dy[D-1] ? -dy : dy;
	assign mag_x  = dx_abs[C-1:0];
	assign mag_y  = dy_abs[C-1:0];
	assign len_w  = (mag_x > mag_y) ? mag_x : mag_y;
	assign len_in = cmd.load ? len_w : len_q;

	dlr_div_lane u_lane_x (
		.clk     (clk),
		.load    (cmd.load),
		.mag_d   (mag_x),
		.neg     (dx[D-1]),
		.len     (len_in),
		.step_en (cmd.div_en),
		.step    (step_x)
	);

	dlr_div_lane u_lane_y (
		.clk     (clk),
		.load    (cmd.load),
		.mag_d   (mag_y),
		.neg     (dy[D-1]),
		.len     (len_in),
		.step_en (cmd.div_en),
		.step    (step_y)
	);

	assign nx     = pos_x_q + {{(P-S){step_x[S-1]}}, step_x};
	assign ny     = pos_y_q + {{(P-S){step_y[S-1]}}, step_y};
	assign diff_x = {nx[P-1], nx} - {tgt_x_q[C-1], tgt_x_q, {F{1'b0}}};
	assign diff_y = {ny[P-1], ny} - {tgt_y_q[C-1], tgt_y_q, {F{1'b0}}};

	assign sts.at_end   = near_end(diff_x) && near_end(diff_y);
	assign sts.len_zero = (len_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_x_q <= {start_x, {F{1'b0}}};
			pos_y_q <= {start_y, {F{1'b0}}};
			tgt_x_q <= stop_x;
			tgt_y_q <= stop_y;
			len_q   <= len_w;
			color_q <= line_color;
		end else if (cmd.tick) begin
			pos_x_q     <= nx;
			pos_y_q     <= ny;
			pix_x_q     <= trunc_pos(pos_x_q);
			pix_y_q     <= trunc_pos(pos_y_q);
			pix_color_q <= color_q;
			last_q      <= sts.at_end;
		end
	end

	assign pixel_x     = pix_x_q;
	assign pixel_y     = pix_y_q;
	assign pixel_color = pix_color_q;
	assign last_pixel  = last_q;

endmodule

@@ sv/dlr_ctrl.sv @@
module dlr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          req_type,
	output logic          out_valid,
	input  logic          out_stall,
	output dlr_pkg::cmd_t cmd,
	input  dlr_pkg::sts_t sts
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]                 state_q;
	logic [dlr_pkg::CNT_W-1:0]  cnt_q;
	logic                       out_valid_q;
	logic                       accept;

	assign in_stall   = (state_q == ST_DIV) || (out_valid_q && out_stall);
	assign accept     = in_valid && !in_stall;
	assign cmd.load   = accept && (req_type == dlr_pkg::REQ_LOAD);
	assign cmd.tick   = accept && (req_type == dlr_pkg::REQ_TICK) && (state_q == ST_RUN);
	assign cmd.div_en = (state_q == ST_DIV) && !sts.len_zero;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE, ST_RUN: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else if (cmd.tick && sts.at_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (sts.len_zero) begin
						state_q <= ST_IDLE;
					end else if (cnt_q == dlr_pkg::CNT_W'(dlr_pkg::FRAC_BITS - 1)) begin
						state_q <= ST_RUN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_tick_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> out_valid_q) else $error("tick did not produce a word");
	a_load_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DIV) && (cnt_q == '0)) else $error("load did not start division");
	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !accept) else $error("word accepted during division");
	a_tick_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |-> !cmd.load && !cmd.div_en) else $error("conflicting commands");
`endif

endmodule

@@ sv/dda_line_rasterizer_core.sv @@
// DDA line rasterizer. A load word (req_type 0) takes two endpoints and a color and
// returns nothing; it captures the line, and the two step dividers then each produce
// FRAC_BITS quotient bits; equal endpoints skip the division and leave the block idle.
// While a line is active each tick word (req_type 1) yields one pixel, so pixels
// stream at one per cycle while out_stall is low; last_pixel marks the end of the
// line, and a tick with no active line is accepted and yields nothing. A load
// during an active line restarts it. A registered output stage holds the pixel while
// out_stall is high; input is stalled only while that stage is full and stalled, or
// while the block is in its divide state.
module dda_line_rasterizer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] stop_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] stop_y,
	input  logic [31:0]                           line_color,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [dlr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [dlr_pkg::COORD_BITS-1:0] pixel_y,
	output logic [31:0]                           pixel_color,
	output logic                                  last_pixel
);

	dlr_pkg::cmd_t cmd;
	dlr_pkg::sts_t sts;

	dlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	dlr_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.start_x     (start_x),
		.start_y     (start_y),
		.stop_x      (stop_x),
		.stop_y      (stop_y),
		.line_color  (line_color),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int     COORD_BITS   = dlr_pkg::COORD_BITS;
	localparam int     FRAC_BITS    = dlr_pkg::FRAC_BITS;
	localparam int     POS_W        = dlr_pkg::POS_W;
	localparam int     STEP_W       = dlr_pkg::STEP_W;
	localparam int     RANDOM_WORDS = 1550;
	localparam int     CYCLE_LIMIT  = 600000;
	localparam int     DRAIN_CYCLES = 40;
	localparam longint ONE          = longint'(1) <<< FRAC_BITS;

	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_NONE,
		EXP_PIXEL
	} exp_kind_t;

	typedef struct packed {
		logic                         req;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic signed [COORD_BITS-1:0] ex;
		logic signed [COORD_BITS-1:0] ey;
		logic [31:0]                  color;
	} word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [31:0]                  color;
		logic                         last;
	} pixel_t;

	typedef struct packed {
		word_t     w;
		exp_kind_t kind;
		pixel_t    px;
	} script_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         req_type;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] stop_x;
	logic signed [COORD_BITS-1:0] stop_y;
	logic [31:0]                  line_color;
	logic                         out_valid;
	logic                         out_stall;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic [31:0]                  pixel_color;
	logic                         last_pixel;

	// line state mirrored from the block
	logic signed [POS_W-1:0]      cur_x, cur_y;
	logic signed [STEP_W-1:0]     inc_x, inc_y;
	logic signed [COORD_BITS-1:0] end_x, end_y;
	logic [31:0]                  ink;
	bit                           drawing;

	pixel_t      pixels_due[$];
	script_row_t script[$];

	int idle_pct;
	int stall_pct;
	int errors;
	int cycles;
	int loads_sent;
	int ticks_sent;
	int pixels_seen;
	int lines_done;
	int words_counted;

	dda_line_rasterizer_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.start_x     (start_x),
		.start_y     (start_y),
		.stop_x      (stop_x),
		.stop_y      (stop_y),
		.line_color  (line_color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
	end

	function automatic bit near_stop(input longint p, input longint t);
		longint d;
		d = p - (t <<< FRAC_BITS);
		return (d < ONE) && (d > -ONE);
	endfunction

	function automatic longint whole_part(input longint p);
		if (p < 0)
			return -((-p) >>> FRAC_BITS);
		return p >>> FRAC_BITS;
	endfunction

	function automatic bit line_at_end();
		return near_stop(cur_x, end_x) && near_stop(cur_y, end_y);
	endfunction

	// returns 1 when the word yields a pixel
	function automatic bit raster_step(input word_t w, output pixel_t px);
		longint dx, dy, adx, ady, span;
		px = '0;
		if (w.req == dlr_pkg::REQ_LOAD) begin
			dx   = longint'($signed(w.ex)) - longint'($signed(w.sx));
			dy   = longint'($signed(w.ey)) - longint'($signed(w.sy));
			adx  = dx < 0 ? -dx : dx;
			ady  = dy < 0 ? -dy : dy;
			span = adx > ady ? adx : ady;
			ink   = w.color;
			end_x = w.ex;
			end_y = w.ey;
			cur_x = POS_W'(longint'($signed(w.sx)) * ONE);
			cur_y = POS_W'(longint'($signed(w.sy)) * ONE);
			if (span == 0) begin
				inc_x   = '0;
				inc_y   = '0;
				drawing = 1'b0;
			end else begin
				inc_x   = STEP_W'((dx * ONE) / span);
				inc_y   = STEP_W'((dy * ONE) / span);
				drawing = !line_at_end();
			end
			return 1'b0;
		end
		if (!drawing)
			return 1'b0;
		px.x     = COORD_BITS'(whole_part(cur_x));
		px.y     = COORD_BITS'(whole_part(cur_y));
		px.color = ink;
		cur_x    = cur_x + inc_x;
		cur_y    = cur_y + inc_y;
		px.last  = line_at_end();
		if (px.last)
			drawing = 1'b0;
		return 1'b1;
	endfunction

	function automatic word_t rand_word();
		word_t w;
		w.req   = 1'($urandom_range(0, 1));
		w.sx    = COORD_BITS'($urandom);
		w.sy    = COORD_BITS'($urandom);
		w.ex    = COORD_BITS'($urandom);
		w.ey    = COORD_BITS'($urandom);
		w.color = $urandom;
		return w;
	endfunction

	function automatic script_row_t load_row(input int sx, input int sy, input int ex,
			input int ey, input logic [31:0] color);
		script_row_t r;
		r.w     = '{req: dlr_pkg::REQ_LOAD, sx: COORD_BITS'(sx), sy: COORD_BITS'(sy),
			ex: COORD_BITS'(ex), ey: COORD_BITS'(ey), color: color};
		r.kind  = EXP_NONE;
		r.px    = '0;
		return r;
	endfunction

	function automatic script_row_t tick_row(input exp_kind_t kind, input int x, input int y,
			input logic [31:0] color, input logic last);
		script_row_t r;
		r.w     = '0;
		r.w.req = dlr_pkg::REQ_TICK;
		r.kind  = kind;
		r.px    = '{x: COORD_BITS'(x), y: COORD_BITS'(y), color: color, last: last};
		return r;
	endfunction

	function automatic int shift_coord(input int s, input int reach);
		int d, e;
		d = int'($urandom_range(0, 2 * reach)) - reach;
		e = s + d;
		if (e > 2047 || e < -2048)
			e = s - d;
		return e;
	endfunction

	task automatic pause_sender();
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	task automatic send_word(input word_t w, input exp_kind_t kind, input pixel_t fixed);
		pixel_t px;
		bit     got;
		in_valid   <= 1'b1;
		req_type   <= w.req;
		start_x    <= w.sx;
		start_y    <= w.sy;
		stop_x     <= w.ex;
		stop_y     <= w.ey;
		line_color <= w.color;
		do @(posedge clk); while (in_stall);
		got = raster_step(w, px);
		if (w.req == dlr_pkg::REQ_LOAD)
			loads_sent++;
		else
			ticks_sent++;
		words_counted++;
		case (kind)
			EXP_MODEL: begin
				if (got)
					pixels_due.push_back(px);
			end
			EXP_PIXEL: begin
				pixels_due.push_back(fixed);
			end
			default: begin
			end
		endcase
	endtask

	task automatic random_line();
		int    sx, sy, ex, ey, reach, adx, ady, span, n, pick;
		word_t w;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			pause_sender();
			send_word(rand_word(), EXP_MODEL, '0);
			return;
		end
		reach = pick < 80 ? 12 : (pick < 95 ? 100 : 0);
		sx = int'($urandom_range(0, 4095)) - 2048;
		sy = int'($urandom_range(0, 4095)) - 2048;
		if (reach == 0) begin
			ex = int'($urandom_range(0, 4095)) - 2048;
			ey = int'($urandom_range(0, 4095)) - 2048;
		end else begin
			ex = shift_coord(sx, reach);
			ey = shift_coord(sy, reach);
		end
		adx  = ex > sx ? ex - sx : sx - ex;
		ady  = ey > sy ? ey - sy : sy - ey;
		span = adx > ady ? adx : ady;
		if (reach == 0)
			n = $urandom_range(0, 30);
		else if ($urandom_range(0, 4) == 0)
			n = $urandom_range(0, span);
		else
			n = span + $urandom_range(0, 2);
		w       = rand_word();
		w.req   = dlr_pkg::REQ_LOAD;
		w.sx    = COORD_BITS'(sx);
		w.sy    = COORD_BITS'(sy);
		w.ex    = COORD_BITS'(ex);
		w.ey    = COORD_BITS'(ey);
		pause_sender();
		send_word(w, EXP_MODEL, '0);
		repeat (n) begin
			w     = rand_word();
			w.req = dlr_pkg::REQ_TICK;
			pause_sender();
			send_word(w, EXP_MODEL, '0);
		end
	endtask

	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			pixels_seen++;
			if (last_pixel)
				lines_done++;
			if (pixels_due.size() == 0) begin
				$error("pixel (%0d,%0d) with none expected", pixel_x, pixel_y);
				errors++;
			end else begin
				want = pixels_due.pop_front();
				if (pixel_x !== want.x) begin
					$error("pixel_x expected %0d got %0d", $signed(want.x), pixel_x);
					errors++;
				end
				if (pixel_y !== want.y) begin
					$error("pixel_y expected %0d got %0d", $signed(want.y), pixel_y);
					errors++;
				end
				if (pixel_color !== want.color) begin
					$error("pixel_color expected %h got %h", want.color, pixel_color);
					errors++;
				end
				if (last_pixel !== want.last) begin
					$error("last_pixel expected %b got %b", want.last, last_pixel);
					errors++;
				end
			end
		end
	end

	initial begin
		int phase;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		req_type   <= dlr_pkg::REQ_TICK;
		start_x    <= '0;
		start_y    <= '0;
		stop_x     <= '0;
		stop_y     <= '0;
		line_color <= '0;
		idle_pct    = 0;
		stall_pct   = 0;
		loads_sent  = 0;
		ticks_sent  = 0;
		words_counted = 0;
		cur_x   = '0;
		cur_y   = '0;
		inc_x   = '0;
		inc_y   = '0;
		end_x   = '0;
		end_y   = '0;
		ink     = '0;
		drawing = 1'b0;

		script.push_back(tick_row(EXP_NONE, 0, 0, 0, 0));
		script.push_back(load_row(0, 0, 3, 0, 32'hffff_ffff));
		script.push_back(tick_row(EXP_PIXEL, 0, 0, 32'hffff_ffff, 0));
		script.push_back(tick_row(EXP_PIXEL, 1, 0, 32'hffff_ffff, 0));
		script.push_back(tick_row(EXP_PIXEL, 2, 0, 32'hffff_ffff, 1));
		script.push_back(tick_row(EXP_NONE, 0, 0, 0, 0));
		// equal endpoints stay idle
		script.push_back(load_row(5, 5, 5, 5, 32'h1234_5678));
		script.push_back(tick_row(EXP_NONE, 0, 0, 0, 0));
		script.push_back(load_row(-2048, -2048, 2047, 2047, 32'h0000_0000));
		script.push_back(tick_row(EXP_MODEL, 0, 0, 0, 0));
		script.push_back(tick_row(EXP_MODEL, 0, 0, 0, 0));
		// reload over an active line
		script.push_back(load_row(2047, -2048, -2048, 2047, 32'ha5a5_a5a5));
		script.push_back(tick_row(EXP_MODEL, 0, 0, 0, 0));
		script.push_back(load_row(0, 0, -1, -5, 32'h5a5a_5a5a));
		repeat (6) script.push_back(tick_row(EXP_MODEL, 0, 0, 0, 0));
		script.push_back(load_row(0, 0, 1, 0, 32'h0000_ffff));
		script.push_back(tick_row(EXP_PIXEL, 0, 0, 32'h0000_ffff, 1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			pause_sender();
			send_word(script[i].w, script[i].kind, script[i].px);
		end

		words_counted = 0;
		while (words_counted < RANDOM_WORDS) begin
			phase = (words_counted * 4) / RANDOM_WORDS;
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 72; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 72; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			random_line();
		end
		in_valid <= 1'b0;

		while (pixels_due.size() != 0)
			@(posedge clk);
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d line loads and %0d pixel ticks sent, %0d pixels checked", loads_sent,
			ticks_sent, pixels_seen);
		$display("%0d lines drawn to the end, %0d mismatches", lines_done, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
